// ===== rtl/sru_pkg.sv =====
package sru_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned MAX_ITEMS_DEFAULT = 64;
	localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

	typedef struct packed {
		logic clear;
		logic vld;
		logic have_last;
		logic keep_ones;
	} scan_ctl_t;

endpackage

// ===== rtl/sru_ram.sv =====
module sru_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/sru_minscan.sv =====
module sru_minscan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sru_pkg::scan_ctl_t            ctl,
	input  logic [sru_pkg::VALUE_W-1:0]   data,
	input  logic [sru_pkg::VALUE_W-1:0]   last_val,
	output logic [sru_pkg::VALUE_W-1:0]   best,
	output logic                          found
);

	import sru_pkg::*;

	logic [VALUE_W-1:0] best_q;
	logic               found_q;
	logic               take;

	// A valid word is a candidate when above the prior minimum and below the best so far; all ones needs a one-word list.
	assign take = ctl.vld && ((data != ALL_ONES) || ctl.keep_ones)
		&& (!ctl.have_last || (data > last_val))
		&& (!found_q || (data < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q <= data;
		end
	end

	assign best  = best_q;
	assign found = found_q;

endmodule

// ===== rtl/sort_unique_values.sv =====
// A word that is not the last of a list is stored, if room remains, while collecting. The last word
// starts (U + 1) selection passes over the N stored words, which find U unique survivors,
// all through one shared compare unit and one store read port.
// Results then leave one at a time, each held until taken; no word is taken until the last result has gone.
// Reset clears the sequencer, the fill count and the overflow flag; the stores are not cleared.
module sort_unique_values #(
	parameter int unsigned MAX_ITEMS = sru_pkg::MAX_ITEMS_DEFAULT,
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1),
	localparam int unsigned TDATA_W = ((sru_pkg::VALUE_W + CW + 2 + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [sru_pkg::VALUE_W-1:0] s_tdata,  // value
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [TDATA_W-1:0]          m_tdata,  // value_res, unique_count, empty_res, overflow
	output logic                        m_tlast
);

	import sru_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ITEMS);

	localparam logic [2:0] S_COLLECT = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_DRAIN   = 3'd2;
	localparam logic [2:0] S_WRAP    = 3'd3;
	localparam logic [2:0] S_EREAD   = 3'd4;
	localparam logic [2:0] S_EOUT    = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      u_q;
	logic               ovf_q;
	logic [AW-1:0]      scan_idx_q;
	logic [AW-1:0]      emit_idx_q;
	logic               have_last_q;
	logic               single_q;
	logic               rd_vld_q;
	logic [VALUE_W-1:0] last_val_q;

	logic               in_acc;
	logic               out_acc;
	logic               full;
	logic [CW-1:0]      fill_after;
	logic [CW-1:0]      fill_m1;
	logic [CW-1:0]      u_m1;
	logic               empty;
	logic [VALUE_W-1:0] store_rd;
	logic [VALUE_W-1:0] sorted_rd;
	logic [VALUE_W-1:0] best;
	logic               found;
	logic [VALUE_W-1:0] value_res;
	scan_ctl_t          scan_ctl;

	assign in_acc     = s_tvalid && s_tready;
	assign out_acc    = m_tvalid && m_tready;
	assign full       = (fill_q == CW'(MAX_ITEMS));
	assign fill_after = full ? fill_q : fill_q + 1'b1;
	assign fill_m1    = fill_q - 1'b1;
	assign u_m1       = u_q - 1'b1;
	assign empty      = (u_q == '0);

	sru_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_W)
	) u_store (
		.clk     (clk),
		.wr_en   (in_acc && !full),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (s_tdata),
		.rd_en   (state_q == S_SCAN),
		.rd_addr (scan_idx_q),
		.rd_data (store_rd)
	);

	assign scan_ctl.clear     = (state_q == S_WRAP) || (in_acc && s_tlast);
	assign scan_ctl.vld       = rd_vld_q;
	assign scan_ctl.have_last = have_last_q;
	assign scan_ctl.keep_ones = single_q;

	sru_minscan u_minscan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.data     (store_rd),
		.last_val (last_val_q),
		.best     (best),
		.found    (found)
	);

	sru_ram #(
		.DEPTH (MAX_ITEMS),
		.WIDTH (VALUE_W)
	) u_sorted (
		.clk     (clk),
		.wr_en   ((state_q == S_WRAP) && found),
		.wr_addr (u_q[AW-1:0]),
		.wr_data (best),
		.rd_en   (state_q == S_EREAD),
		.rd_addr (emit_idx_q),
		.rd_data (sorted_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			fill_q      <= '0;
			u_q         <= '0;
			ovf_q       <= 1'b0;
			scan_idx_q  <= '0;
			emit_idx_q  <= '0;
			have_last_q <= 1'b0;
			single_q    <= 1'b0;
			rd_vld_q    <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == S_SCAN);
			unique case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						fill_q <= fill_after;
						if (full) begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q     <= S_SCAN;
							scan_idx_q  <= '0;
							u_q         <= '0;
							have_last_q <= 1'b0;
							single_q    <= (fill_after == CW'(1));
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q == fill_m1[AW-1:0]) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (found) begin
						u_q         <= u_q + 1'b1;
						have_last_q <= 1'b1;
						scan_idx_q  <= '0;
						state_q     <= S_SCAN;
					end else begin
						emit_idx_q <= '0;
						state_q    <= empty ? S_EOUT : S_EREAD;
					end
				end
				S_EREAD: begin
					state_q <= S_EOUT;
				end
				S_EOUT: begin
					if (out_acc) begin
						if (m_tlast) begin
							state_q <= S_COLLECT;
							fill_q  <= '0;
							u_q     <= '0;
							ovf_q   <= 1'b0;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q    <= S_EREAD;
						end
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_WRAP) && found) begin
			last_val_q <= best;
		end
	end

	assign s_tready  = (state_q == S_COLLECT);
	assign m_tvalid  = (state_q == S_EOUT);
	assign m_tlast   = empty || (emit_idx_q == u_m1[AW-1:0]);
	assign value_res = empty ? '0 : sorted_rd;

	always_comb begin
		m_tdata                      = '0;
		m_tdata[VALUE_W-1:0]         = value_res;
		m_tdata[VALUE_W +: CW]       = u_q;
		m_tdata[VALUE_W + CW]        = empty;
		m_tdata[VALUE_W + CW + 1]    = ovf_q;
	end

	// The unique count can never exceed the number of stored words.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_q <= fill_q)
		else $error("unique count exceeds fill count");

	// Input and output sides are never open together.
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output open together");

	// An empty result is the only one of its list.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && empty) |-> (m_tlast && (u_q == '0)))
		else $error("empty result not marked last");

	// The last word of a list closes the input side.
	a_final_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still open after last word");

endmodule
